// ----- design/fct_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types, result codes and constant text for the cuesheet tag extractor.
// ----------------------------------------------------------------------------
package fct_pkg;

	localparam logic [1:0] KIND_START  = 2'd0;
	localparam logic [1:0] KIND_VALUE  = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BAD_MAGIC   = 3'd1;
	localparam logic [2:0] ST_TRUNCATED   = 3'd2;
	localparam logic [2:0] ST_BAD_TYPE    = 3'd3;
	localparam logic [2:0] ST_NO_EQUALS   = 3'd4;
	localparam logic [2:0] ST_NO_CUESHEET = 3'd5;

	localparam logic [6:0] MAX_BLOCK_TYPE     = 7'd6;
	localparam logic [6:0] COMMENT_BLOCK_TYPE = 7'd4;
	localparam logic [7:0] EQUALS_CHAR        = 8'h3d;
	localparam logic [3:0] KEY_LEN            = 4'd8;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value_byte;
		logic [2:0] status;
		logic       is_last;
	} result_t;

	// "fLaC"
	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0:    b = 8'h66;
			2'd1:    b = 8'h4c;
			2'd2:    b = 8'h61;
			default: b = 8'h43;
		endcase
		return b;
	endfunction

	// "cuesheet"
	function automatic logic [7:0] key_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0:    b = 8'h63;
			3'd1:    b = 8'h75;
			3'd2:    b = 8'h65;
			3'd3:    b = 8'h73;
			3'd4:    b = 8'h68;
			3'd5:    b = 8'h65;
			3'd6:    b = 8'h65;
			default: b = 8'h74;
		endcase
		return b;
	endfunction

	function automatic result_t mk_result(input logic [1:0] kind, input logic [7:0] val,
			input logic [2:0] st);
		result_t r;
		r.kind       = kind;
		r.value_byte = val;
		r.status     = st;
		r.is_last    = 1'b0;
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- design/fct_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fct_stream_if
// Valid/ready channels: file bytes in, extracted results out.
// ----------------------------------------------------------------------------
interface fct_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_file;

	modport source (output valid, output data_byte, output end_of_file, input ready);
	modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface fct_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] value_byte;
	logic [2:0] status;
	logic       is_last;

	modport source (output valid, output kind, output value_byte, output status,
		output is_last, input ready);
	modport sink   (input valid, input kind, input value_byte, input status,
		input is_last, output ready);
endinterface
`default_nettype wire

// ----- design/fct_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fct_parser
// Per-byte metadata walker: updates parse state and forms up to two results.
// ----------------------------------------------------------------------------
module fct_parser (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            go,
	input  wire logic [7:0]      data_byte,
	input  wire logic            end_of_file,
	output fct_pkg::result_t     res0,
	output fct_pkg::result_t     res1,
	output logic [1:0]           res_n
);

	typedef enum logic [2:0] {
		PH_MAGIC,
		PH_HEADER,
		PH_SKIP,
		PH_VENDOR_LEN,
		PH_VENDOR,
		PH_COUNT,
		PH_COMMENT_LEN,
		PH_COMMENT
	} phase_t;

	phase_t      ph_q, ph_d;
	logic [1:0]  idx_q, idx_d;
	logic [31:0] shift_q, shift_d;
	logic [31:0] brem_q, brem_d;
	logic [31:0] crem_q, crem_d;
	logic        last_q, last_d;
	logic [3:0]  kpos_q, kpos_d;
	logic        kmatch_q, kmatch_d;
	logic        eq_q, eq_d;
	logic        found_q, found_d;
	logic        given_q, given_d;

	fct_pkg::result_t res [2];

	always_comb begin
		logic [1:0]  n;
		logic [1:0]  idx_inc;
		logic        fld_done;
		logic [31:0] shift_be;
		logic [31:0] shift_le;
		logic [6:0]  hdr_type;

		n        = 2'd0;
		res[0]   = '0;
		res[1]   = '0;
		idx_inc  = idx_q + 2'd1;
		fld_done = (idx_q == 2'd3);
		shift_be = {shift_q[23:0], data_byte};
		shift_le = shift_q | ({24'd0, data_byte} << {idx_q, 3'b000});
		hdr_type = shift_be[30:24];

		ph_d     = ph_q;
		idx_d    = idx_q;
		shift_d  = shift_q;
		brem_d   = brem_q;
		crem_d   = crem_q;
		last_d   = last_q;
		kpos_d   = kpos_q;
		kmatch_d = kmatch_q;
		eq_d     = eq_q;
		found_d  = found_q;
		given_d  = given_q;

		if (!given_q) begin
			case (ph_q)
				PH_MAGIC: begin
					if (data_byte != fct_pkg::magic_byte(idx_q)) begin
						res[n[0]] = fct_pkg::mk_result(fct_pkg::KIND_STATUS, 8'd0,
							fct_pkg::ST_BAD_MAGIC);
						n = n + 2'd1;
						given_d = 1'b1;
					end else if (fld_done) begin
						ph_d = PH_HEADER; idx_d = 2'd0; shift_d = '0;
					end else begin
						idx_d = idx_inc;
					end
				end
				PH_HEADER: begin
					shift_d = shift_be;
					idx_d   = idx_inc;
					if (fld_done) begin
						last_d = shift_be[31];
						if (hdr_type > fct_pkg::MAX_BLOCK_TYPE) begin
							res[n[0]] = fct_pkg::mk_result(fct_pkg::KIND_STATUS, 8'd0,
								fct_pkg::ST_BAD_TYPE);
							n = n + 2'd1;
							given_d = 1'b1;
						end else if (hdr_type == fct_pkg::COMMENT_BLOCK_TYPE) begin
							ph_d = PH_VENDOR_LEN; idx_d = 2'd0; shift_d = '0;
						end else begin
							brem_d = {8'd0, shift_be[23:0]};
							ph_d   = PH_SKIP;
							if (shift_be[23:0] == 24'd0) begin
								if (last_d) begin
									res[n[0]] = fct_pkg::mk_result(fct_pkg::KIND_STATUS, 8'd0,
										found_d ? fct_pkg::ST_OK : fct_pkg::ST_NO_CUESHEET);
									n = n + 2'd1;
									given_d = 1'b1;
								end else begin
									ph_d = PH_HEADER; idx_d = 2'd0; shift_d = '0;
								end
							end
						end
					end
				end
				PH_SKIP: begin
					brem_d = brem_q - 32'd1;
					if (brem_d == 32'd0) begin
						if (last_d) begin
							res[n[0]] = fct_pkg::mk_result(fct_pkg::KIND_STATUS, 8'd0,
								found_d ? fct_pkg::ST_OK : fct_pkg::ST_NO_CUESHEET);
							n = n + 2'd1;
							given_d = 1'b1;
						end else begin
							ph_d = PH_HEADER; idx_d = 2'd0; shift_d = '0;
						end
					end
				end
				PH_VENDOR_LEN: begin
					shift_d = shift_le;
					idx_d   = idx_inc;
					if (fld_done) begin
						brem_d = shift_le;
						if (shift_le == 32'd0) begin
							ph_d = PH_COUNT; idx_d = 2'd0; shift_d = '0;
						end else begin
							ph_d = PH_VENDOR;
						end
					end
				end
				PH_VENDOR: begin
					brem_d = brem_q - 32'd1;
					if (brem_d == 32'd0) begin
						ph_d = PH_COUNT; idx_d = 2'd0; shift_d = '0;
					end
				end
				PH_COUNT: begin
					shift_d = shift_le;
					idx_d   = idx_inc;
					if (fld_done) begin
						crem_d = shift_le;
						if (shift_le == 32'd0) begin
							if (last_d) begin
								res[n[0]] = fct_pkg::mk_result(fct_pkg::KIND_STATUS, 8'd0,
									found_d ? fct_pkg::ST_OK : fct_pkg::ST_NO_CUESHEET);
								n = n + 2'd1;
								given_d = 1'b1;
							end else begin
								ph_d = PH_HEADER; idx_d = 2'd0; shift_d = '0;
							end
						end else begin
							ph_d = PH_COMMENT_LEN; idx_d = 2'd0; shift_d = '0;
						end
					end
				end
				PH_COMMENT_LEN: begin
					shift_d = shift_le;
					idx_d   = idx_inc;
					if (fld_done) begin
						brem_d   = shift_le;
						kpos_d   = 4'd0;
						kmatch_d = 1'b1;
						eq_d     = 1'b0;
						if (shift_le == 32'd0) begin
							res[n[0]] = fct_pkg::mk_result(fct_pkg::KIND_STATUS, 8'd0,
								fct_pkg::ST_NO_EQUALS);
							n = n + 2'd1;
							given_d = 1'b1;
						end else begin
							ph_d = PH_COMMENT;
						end
					end
				end
				PH_COMMENT: begin
					if (!eq_q) begin
						if (data_byte == fct_pkg::EQUALS_CHAR) begin
							eq_d     = 1'b1;
							kmatch_d = kmatch_q && (kpos_q == fct_pkg::KEY_LEN);
							if (kmatch_d) begin
								res[n[0]] = fct_pkg::mk_result(fct_pkg::KIND_START, 8'd0,
									fct_pkg::ST_OK);
								n = n + 2'd1;
								found_d = 1'b1;
							end
						end else if (kmatch_q) begin
							if (kpos_q < fct_pkg::KEY_LEN
									&& data_byte == fct_pkg::key_byte(kpos_q[2:0])) begin
								kpos_d = kpos_q + 4'd1;
							end else begin
								kmatch_d = 1'b0;
							end
						end
					end else if (kmatch_q) begin
						res[n[0]] = fct_pkg::mk_result(fct_pkg::KIND_VALUE, data_byte,
							fct_pkg::ST_OK);
						n = n + 2'd1;
					end
					brem_d = brem_q - 32'd1;
					if (brem_d == 32'd0) begin
						if (!eq_d) begin
							res[n[0]] = fct_pkg::mk_result(fct_pkg::KIND_STATUS, 8'd0,
								fct_pkg::ST_NO_EQUALS);
							n = n + 2'd1;
							given_d = 1'b1;
						end else begin
							crem_d = crem_q - 32'd1;
							if (crem_d == 32'd0) begin
								if (last_d) begin
									res[n[0]] = fct_pkg::mk_result(fct_pkg::KIND_STATUS, 8'd0,
										found_d ? fct_pkg::ST_OK : fct_pkg::ST_NO_CUESHEET);
									n = n + 2'd1;
									given_d = 1'b1;
								end else begin
									ph_d = PH_HEADER; idx_d = 2'd0; shift_d = '0;
								end
							end else begin
								ph_d = PH_COMMENT_LEN; idx_d = 2'd0; shift_d = '0;
							end
						end
					end
				end
				default: begin
					res[n[0]] = fct_pkg::mk_result(fct_pkg::KIND_STATUS, 8'd0,
						fct_pkg::ST_TRUNCATED);
					n = n + 2'd1;
					given_d = 1'b1;
				end
			endcase
		end

		// end of file without a status yet
		if (end_of_file && !given_d) begin
			if (ph_d == PH_MAGIC) begin
				res[n[0]] = fct_pkg::mk_result(fct_pkg::KIND_STATUS, 8'd0,
					fct_pkg::ST_BAD_MAGIC);
			end else if ((ph_d == PH_HEADER && idx_d == 2'd0) || ph_d == PH_SKIP) begin
				res[n[0]] = fct_pkg::mk_result(fct_pkg::KIND_STATUS, 8'd0,
					found_d ? fct_pkg::ST_OK : fct_pkg::ST_NO_CUESHEET);
			end else begin
				res[n[0]] = fct_pkg::mk_result(fct_pkg::KIND_STATUS, 8'd0,
					fct_pkg::ST_TRUNCATED);
			end
			n = n + 2'd1;
			given_d = 1'b1;
		end

		if (n == 2'd1) begin
			res[0].is_last = 1'b1;
		end else if (n == 2'd2) begin
			res[1].is_last = 1'b1;
		end

		if (end_of_file) begin
			ph_d     = PH_MAGIC;
			idx_d    = 2'd0;
			shift_d  = '0;
			brem_d   = '0;
			crem_d   = '0;
			last_d   = 1'b0;
			kpos_d   = 4'd0;
			kmatch_d = 1'b1;
			eq_d     = 1'b0;
			found_d  = 1'b0;
			given_d  = 1'b0;
		end

		res_n = n;
	end

	assign res0 = res[0];
	assign res1 = res[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q     <= PH_MAGIC;
			idx_q    <= 2'd0;
			shift_q  <= '0;
			brem_q   <= '0;
			crem_q   <= '0;
			last_q   <= 1'b0;
			kpos_q   <= 4'd0;
			kmatch_q <= 1'b1;
			eq_q     <= 1'b0;
			found_q  <= 1'b0;
			given_q  <= 1'b0;
		end else if (go) begin
			ph_q     <= ph_d;
			idx_q    <= idx_d;
			shift_q  <= shift_d;
			brem_q   <= brem_d;
			crem_q   <= crem_d;
			last_q   <= last_d;
			kpos_q   <= kpos_d;
			kmatch_q <= kmatch_d;
			eq_q     <= eq_d;
			found_q  <= found_d;
			given_q  <= given_d;
		end
	end

	a_eof_resets: assert property (@(posedge clk) disable iff (!arst_n)
		go && end_of_file |=> ph_q == PH_MAGIC && !given_q && !found_q)
		else $error("parse state not cleared after final byte");

	a_last_on_eof: assert property (@(posedge clk) disable iff (!arst_n)
		go && end_of_file && !given_q |-> res_n != 2'd0)
		else $error("final byte without a status");

	a_key_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kpos_q <= fct_pkg::KEY_LEN)
		else $error("key position past key length");

endmodule
`default_nettype wire

// ----- design/fct_res_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fct_res_fifo
// Four-entry result queue: up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
module fct_res_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [1:0]       push_n,
	input  wire fct_pkg::result_t din0,
	input  wire fct_pkg::result_t din1,
	output logic                  room,
	input  wire logic             pop,
	output logic                  dout_valid,
	output fct_pkg::result_t      dout
);

	fct_pkg::result_t mem_q [4];
	logic [1:0] wp_q;
	logic [1:0] rp_q;
	logic [2:0] cnt_q;
	logic [3:0] cnt_sum;

	assign room       = (cnt_q <= 3'd2);
	assign dout_valid = (cnt_q != 3'd0);
	assign dout       = mem_q[rp_q];
	assign cnt_sum    = {1'b0, cnt_q} + {2'b00, push_n};

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wp_q] <= din0;
		end
		if (push_n == 2'd2) begin
			mem_q[wp_q + 2'd1] <= din1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 2'd0;
			rp_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wp_q  <= wp_q + push_n;
			rp_q  <= rp_q + {1'b0, pop && dout_valid};
			cnt_q <= 3'(cnt_sum - {3'b000, pop && dout_valid});
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> cnt_sum <= 4'd4)
		else $error("result queue overflow");

	a_push_max: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd3)
		else $error("more than two results pushed");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop && dout_valid && push_n == 2'd0 |=> cnt_q == $past(cnt_q) - 3'd1)
		else $error("pop did not decrement occupancy");

endmodule
`default_nettype wire

// ----- design/flac_cuesheet_tag_extractor_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flac_cuesheet_tag_extractor_unit
// Walks FLAC metadata one byte per item and extracts the "cuesheet" comment.
// ----------------------------------------------------------------------------
// One file byte is taken per clock while the queue has room. Each byte is
// registered, walked through the metadata parser once the queue can take its
// results, and its zero, one or two results go into a four-entry result queue
// that drives the output channel. Input throughput is one byte per cycle while
// the queue has room for two results; the queue drains one result per cycle
// while the output is ready, so bytes that stream a cuesheet value sustain
// full rate and a byte giving two results fills the queue faster than it
// drains. One status result ends every file; after the final byte the
// parser is back in its reset state for the next file.
module flac_cuesheet_tag_extractor_unit (
	input  wire logic      clk,
	input  wire logic      arst_n,
	fct_byte_if.sink       in_ch,
	fct_result_if.source   out_ch
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;
	logic       room;
	logic       go;
	logic [1:0] res_n;

	fct_pkg::result_t res0;
	fct_pkg::result_t res1;
	fct_pkg::result_t head;

	assign go          = valid_s1 && room;
	assign in_ch.ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.data_byte;
			eof_s1  <= in_ch.end_of_file;
		end
	end

	fct_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (go),
		.data_byte   (byte_s1),
		.end_of_file (eof_s1),
		.res0        (res0),
		.res1        (res1),
		.res_n       (res_n)
	);

	fct_res_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (go ? res_n : 2'd0),
		.din0       (res0),
		.din1       (res1),
		.room       (room),
		.pop        (out_ch.ready),
		.dout_valid (out_ch.valid),
		.dout       (head)
	);

	assign out_ch.kind       = head.kind;
	assign out_ch.value_byte = head.value_byte;
	assign out_ch.status     = head.status;
	assign out_ch.is_last    = head.is_last;

	a_go_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> valid_s1 && room)
		else $error("parser stepped without a held item");

	a_hold_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !room |=> valid_s1 && $stable(byte_s1) && $stable(eof_s1))
		else $error("held item lost while queue full");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ch.ready)
		else $error("input stalled with empty stage");

endmodule
`default_nettype wire
